@@ hw/rtl/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Provisioning frame deframer package
// Shared item types, operation and event codes, and the header character table.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned EventW    = 3;
  localparam int unsigned PosW      = 9;
  localparam int unsigned IdleW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Frame layout positions.
  localparam logic [PosW-1:0] PosHdrEnd  = 9'd6;
  localparam logic [PosW-1:0] PosVersion = 9'd6;
  localparam logic [PosW-1:0] PosType    = 9'd7;
  localparam logic [PosW-1:0] PosLength  = 9'd8;
  localparam logic [PosW-1:0] PosPayload = 9'd9;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgProtocolVersion = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRpcFrameType    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdleTimeout     = 2'd2;

  localparam logic [ByteW-1:0] ProtocolVersionRst = 8'd1;
  localparam logic [ByteW-1:0] RpcFrameTypeRst    = 8'd3;
  localparam logic [IdleW-1:0] IdleTimeoutRst     = 16'd50;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_kind_e;

  typedef enum logic [EventW-1:0] {
    EV_PAYLOAD   = 3'd0,
    EV_RPC_GOOD  = 3'd1,
    EV_CSUM_ERR  = 3'd2,
    EV_OTHER_GOOD = 3'd3,
    EV_TIMEOUT   = 3'd4
  } event_e;

  typedef struct packed {
    logic             command;
    logic [ByteW-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [ByteW-1:0]  payload_byte;
    logic [ByteW-1:0]  payload_index;
    logic [ByteW-1:0]  frame_type;
    logic [ByteW-1:0]  payload_length;
  } out_item_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    op_kind_e         kind;
    logic [ByteW-1:0] data;
  } op_t;

  // Expected ASCII character at each header position.
  function automatic logic [ByteW-1:0] hdr_char(input logic [2:0] idx);
    logic [ByteW-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h49; // I
      3'd1:    c = 8'h4D; // M
      3'd2:    c = 8'h50; // P
      3'd3:    c = 8'h52; // R
      3'd4:    c = 8'h4F; // O
      3'd5:    c = 8'h56; // V
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/pfd_stream_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one item of type T per accepted handshake.
// ----------------------------------------------------------------------------
interface pfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/provisioning_frame_deframer.sv @@
// Path: an accepted item is written into the queue, then the parser's result for it is registered.
// Throughput: one item per cycle while the output is not stalled; the parser state updates as each item is taken.
// A two-entry queue lets the input keep accepting, until it is full, while a result waits on output.
// Reset: asynchronous, active low; parser idle, queue and output empty,
// configuration registers at their defaults (version 1, RPC type 3, timeout 50).
// ----------------------------------------------------------------------------
// Provisioning frame deframer
// Parses header, version, type, length, payload and checksum of provisioning frames, and reports idle timeouts.
// ----------------------------------------------------------------------------
module provisioning_frame_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfd_pkg::CfgDataW-1:0] cfg_data_i,
  pfd_stream_if.sink                   in_i,
  pfd_stream_if.source                 out_o
);
  import pfd_pkg::*;

  logic op_valid;
  logic op_pop;
  op_t  op;

  pfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_i.payload),
    .in_ready_o (in_i.ready),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  pfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload),
    .out_ready_i (out_o.ready)
  );

endmodule

@@ hw/rtl/pfd_front.sv @@
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts input items, classifies them as bytes or ticks, and queues them.
// ----------------------------------------------------------------------------
module pfd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  pfd_pkg::in_item_t in_item_i,
  output logic            in_ready_o,
  output logic            op_valid_o,
  output pfd_pkg::op_t    op_o,
  input  logic            op_pop_i
);
  import pfd_pkg::*;

  op_t        mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  op_t        op_new;

  assign in_ready_o = (cnt_q != 2'd2);
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = op_pop_i && op_valid_o;

  always_comb begin
    op_new.kind = in_item_i.command ? OP_TICK : OP_BYTE;
    op_new.data = in_item_i.rx_byte;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

@@ hw/rtl/pfd_back.sv @@
// ----------------------------------------------------------------------------
// Deframer back end
// Runs the frame parser on queued operations and registers the result item.
// ----------------------------------------------------------------------------
module pfd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         op_valid_i,
  input  pfd_pkg::op_t                 op_i,
  output logic                         op_pop_o,
  output logic                         out_valid_o,
  output pfd_pkg::out_item_t           out_item_o,
  input  logic                         out_ready_i
);
  import pfd_pkg::*;

  logic [ByteW-1:0] version_q;
  logic [ByteW-1:0] rpc_type_q;
  logic [IdleW-1:0] timeout_q;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [IdleW-1:0] idle_q, idle_d;

  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q;
  logic             emit;
  event_e           ev;
  logic [ByteW-1:0] ev_byte, ev_index;

  logic             go;
  logic [ByteW-1:0] want;
  logic [PosW-1:0]  end_pos;
  logic [ByteW-1:0] sum_add;
  logic [PosW-1:0]  pay_idx;

  assign go       = op_valid_i && (!out_valid_q || out_ready_i);
  assign op_pop_o = go;

  assign want    = (pos_q < PosHdrEnd) ? hdr_char(pos_q[2:0]) : version_q;
  assign end_pos = PosPayload + {1'b0, len_q};
  assign sum_add = sum_q + op_i.data;
  assign pay_idx = pos_q - PosPayload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q  <= ProtocolVersionRst;
      rpc_type_q <= RpcFrameTypeRst;
      timeout_q  <= IdleTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgProtocolVersion: version_q  <= cfg_data_i[ByteW-1:0];
        CfgRpcFrameType:    rpc_type_q <= cfg_data_i[ByteW-1:0];
        CfgIdleTimeout:     timeout_q  <= cfg_data_i[IdleW-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    pos_d    = pos_q;
    type_d   = type_q;
    len_d    = len_q;
    sum_d    = sum_q;
    idle_d   = idle_q;
    emit     = 1'b0;
    ev       = EV_PAYLOAD;
    ev_byte  = '0;
    ev_index = '0;
    if (go) begin
      if (op_i.kind == OP_TICK) begin
        if (idle_q >= timeout_q) begin
          idle_d = '0;
          emit   = (pos_q != '0);
          ev     = EV_TIMEOUT;
          pos_d  = '0;
          type_d = '0;
          len_d  = '0;
          sum_d  = '0;
        end else begin
          idle_d = idle_q + 1'b1;
        end
      end else if (pos_q <= PosVersion) begin
        // Header and version bytes: a mismatch drops the frame silently.
        if (op_i.data != want) begin
          pos_d  = '0;
          type_d = '0;
          len_d  = '0;
          sum_d  = '0;
        end else begin
          sum_d  = sum_add;
          pos_d  = pos_q + 1'b1;
          idle_d = '0;
        end
      end else if (pos_q == PosType || pos_q == PosLength) begin
        if (pos_q == PosType) begin
          type_d = op_i.data;
        end else begin
          len_d = op_i.data;
        end
        sum_d  = sum_add;
        pos_d  = pos_q + 1'b1;
        idle_d = '0;
      end else begin
        idle_d = '0;
        emit   = 1'b1;
        if (pos_q < end_pos) begin
          ev       = EV_PAYLOAD;
          ev_byte  = op_i.data;
          ev_index = pay_idx[ByteW-1:0];
          sum_d    = sum_add;
          pos_d    = pos_q + 1'b1;
        end else begin
          if (op_i.data != sum_q) begin
            ev = EV_CSUM_ERR;
          end else if (type_q == rpc_type_q) begin
            ev = EV_RPC_GOOD;
          end else begin
            ev = EV_OTHER_GOOD;
          end
          pos_d  = '0;
          type_d = '0;
          len_d  = '0;
          sum_d  = '0;
        end
      end
    end
  end

  always_comb begin
    if (go) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      type_q      <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      type_q      <= type_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result reports the type and length held before the frame ends.
  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_item_q.event_res      <= ev;
      out_item_q.payload_byte   <= ev_byte;
      out_item_q.payload_index  <= ev_index;
      out_item_q.frame_type     <= type_q;
      out_item_q.payload_length <= len_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hw/rtl/pfd_checker.sv @@
// ----------------------------------------------------------------------------
// Deframer port checker
// Checks output handshake behavior and result field consistency.
// ----------------------------------------------------------------------------
module pfd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [pfd_pkg::EventW-1:0] out_event_i,
  input logic [pfd_pkg::ByteW-1:0]  out_byte_i,
  input logic [pfd_pkg::ByteW-1:0]  out_index_i,
  input logic [pfd_pkg::ByteW-1:0]  out_length_i
);
  import pfd_pkg::*;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_event_i) && $stable(out_byte_i) && $stable(out_index_i))
    else $error("result changed while stalled");

  // Only payload results carry a data byte and an index.
  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_event_i != EV_PAYLOAD |-> out_byte_i == '0 && out_index_i == '0)
    else $error("verdict result carries payload data");

  // A payload byte always lies inside the announced length.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_event_i == EV_PAYLOAD |-> out_index_i < out_length_i)
    else $error("payload index beyond frame length");

endmodule

bind provisioning_frame_deframer pfd_checker u_pfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_event_i  (out_o.payload.event_res),
  .out_byte_i   (out_o.payload.payload_byte),
  .out_index_i  (out_o.payload.payload_index),
  .out_length_i (out_o.payload.payload_length)
);
